// ===== hw/rtl/swrc_pkg.sv =====
package swrc_pkg;

  localparam int unsigned MaxRows = 256;
  localparam int unsigned MaxCols = 256;
  localparam int unsigned RowW = $clog2(MaxRows);
  localparam int unsigned ColW = $clog2(MaxCols);
  localparam int unsigned AddrW = RowW + ColW;
  localparam int unsigned SizeW = 9;
  localparam int unsigned StepW = 7;

  localparam logic OpWrite = 1'b0;
  localparam logic OpCast = 1'b1;

  localparam logic [1:0] CfgRows = 2'd0;
  localparam logic [1:0] CfgCols = 2'd1;
  localparam logic [1:0] CfgMode = 2'd2;

  typedef enum logic [2:0] {
    StIdle,
    StOrigin,
    StStep,
    StScan,
    StLand,
    StDone
  } swrc_state_e;

  typedef struct packed {
    logic signed [2:0] dr;
    logic signed [2:0] dc;
  } swrc_dir_t;

  function automatic swrc_dir_t swrc_dir(input logic [4:0] nb, input logic [3:0] bin);
    swrc_dir_t d;
    d = '0;
    if (nb == 5'd8) begin
      case (bin[2:0])
        3'd0: d = '{3'sd0, 3'sd1};
        3'd1: d = '{-3'sd1, 3'sd1};
        3'd2: d = '{-3'sd1, 3'sd0};
        3'd3: d = '{-3'sd1, -3'sd1};
        3'd4: d = '{3'sd0, -3'sd1};
        3'd5: d = '{3'sd1, -3'sd1};
        3'd6: d = '{3'sd1, 3'sd0};
        default: d = '{3'sd1, 3'sd1};
      endcase
    end else if (nb == 5'd12) begin
      case (bin)
        4'd0: d = '{3'sd0, 3'sd1};
        4'd1: d = '{-3'sd1, 3'sd2};
        4'd2: d = '{-3'sd2, 3'sd1};
        4'd3: d = '{-3'sd1, 3'sd0};
        4'd4: d = '{-3'sd2, -3'sd1};
        4'd5: d = '{-3'sd1, -3'sd2};
        4'd6: d = '{3'sd0, -3'sd1};
        4'd7: d = '{3'sd1, -3'sd2};
        4'd8: d = '{3'sd2, -3'sd1};
        4'd9: d = '{3'sd1, 3'sd0};
        4'd10: d = '{3'sd2, 3'sd1};
        default: d = '{3'sd1, 3'sd2};
      endcase
    end else begin
      case (bin)
        4'd0: d = '{3'sd0, 3'sd1};
        4'd1: d = '{-3'sd1, 3'sd2};
        4'd2: d = '{-3'sd1, 3'sd1};
        4'd3: d = '{-3'sd2, 3'sd1};
        4'd4: d = '{-3'sd1, 3'sd0};
        4'd5: d = '{-3'sd2, -3'sd1};
        4'd6: d = '{-3'sd1, -3'sd1};
        4'd7: d = '{-3'sd1, -3'sd2};
        4'd8: d = '{3'sd0, -3'sd1};
        4'd9: d = '{3'sd1, -3'sd2};
        4'd10: d = '{3'sd1, -3'sd1};
        4'd11: d = '{3'sd2, -3'sd1};
        4'd12: d = '{3'sd1, 3'sd0};
        4'd13: d = '{3'sd2, 3'sd1};
        4'd14: d = '{3'sd1, 3'sd1};
        default: d = '{3'sd1, 3'sd2};
      endcase
    end
    return d;
  endfunction

  // size by 3 through a reciprocal multiply, sizes up to 256
  function automatic logic [6:0] swrc_third(input logic [8:0] v);
    logic [17:0] p;
    p = {9'd0, v} * 18'd171;
    return p[15:9];
  endfunction

endpackage

// ===== hw/rtl/stroke_width_ray_cast.sv =====
// channel  | dir | handshake      | payload
// s_axis   | in  | tvalid/tready  | tdata, tuser = operation
// m_axis   | out | tvalid/tready  | tdata
// cfg      | in  | cfg_valid/rdy  | cfg_index, cfg_data
// a write is stored when it is taken; a cast runs StOrigin, then StStep and StLand for
// each plain step, a StScan of the 3x3 window after a step that lands on a white pixel,
// and StDone, all paced by the one read port of the store
// reset clears control registers and sets the sizes to 256 and the mode to 0; the store is not cleared
// one cast at a time; the result waits in the output register, and a new item
// is taken while it waits only if it is a write
module stroke_width_ray_cast import swrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pixel_row, pixel_col, is_boundary, gray_white, direction_bin, pad
  input  logic [23:0] s_axis_tdata,
  // operation
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // ray_ok, origin_row, origin_col, end_row, end_col, step_count
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  logic [5:0] mem_q [2**AddrW];
  logic [5:0] rd_q;
  logic [AddrW-1:0] raddr;
  logic ren;

  swrc_state_e st_q, st_d;
  logic [8:0] rows_q, cols_q;
  logic [1:0] mode_q;
  logic [RowW-1:0] org_r_q;
  logic [ColW-1:0] org_c_q;
  logic [RowW-1:0] cr_q, cr_d;
  logic [ColW-1:0] cc_q, cc_d;
  logic [RowW-1:0] nr_q, nr_d;
  logic [ColW-1:0] nc_q, nc_d;
  logic [StepW-1:0] dist_q, dist_d;
  logic [3:0] bin_q, bin_d;
  logic [3:0] k_q, k_d;
  logic ok_q, ok_d;
  logic ovalid_q;
  logic [39:0] odata_q;
  logic fin;
  logic n_in_prev;
  logic [RowW-1:0] pr_q;
  logic [ColW-1:0] pc_q;

  logic [8:0] rows, cols;
  logic [4:0] nb;
  logic [6:0] lim;
  swrc_dir_t dir;
  logic signed [RowW+1:0] sr;
  logic signed [ColW+1:0] sc;
  logic step_in;
  logic [3:0] krow, kcol;
  logic signed [RowW+1:0] mr;
  logic signed [ColW+1:0] mc;
  logic n_in;
  logic [4:0] opp, b1, b2, t;
  logic acc;

  assign rows = (rows_q == 9'd0) ? 9'd1 : (rows_q > 9'(MaxRows)) ? 9'(MaxRows) : rows_q;
  assign cols = (cols_q == 9'd0) ? 9'd1 : (cols_q > 9'(MaxCols)) ? 9'(MaxCols) : cols_q;
  assign lim = swrc_third((rows < cols) ? rows : cols);
  assign nb = (mode_q == 2'd0) ? 5'd8 : (mode_q == 2'd1) ? 5'd12 : 5'd16;
  assign dir = swrc_dir(nb, bin_q);
  assign sr = $signed({2'b00, cr_q}) + (RowW+2)'(dir.dr);
  assign sc = $signed({2'b00, cc_q}) + (ColW+2)'(dir.dc);
  assign step_in = (sr >= 0) && (sr < $signed({1'b0, rows})) &&
                   (sc >= 0) && (sc < $signed({1'b0, cols}));
  // neighbor k of the 3x3 window, row by row
  assign krow = (k_q >= 4'd6) ? 4'd2 : (k_q >= 4'd3) ? 4'd1 : 4'd0;
  assign kcol = k_q - krow - krow - krow;
  assign mr = $signed({2'b00, nr_q}) + $signed((RowW+2)'(krow)) - (RowW+2)'(1);
  assign mc = $signed({2'b00, nc_q}) + $signed((ColW+2)'(kcol)) - (ColW+2)'(1);
  assign n_in = (mr >= 0) && (mr < $signed({1'b0, rows})) &&
                (mc >= 0) && (mc < $signed({1'b0, cols}));
  assign t = 5'(bin_q) + (nb >> 1);
  assign opp = (t >= nb) ? t - nb : t;
  assign b1 = (opp + 5'd1 >= nb) ? opp + 5'd1 - nb : opp + 5'd1;
  assign b2 = (opp == 5'd0) ? nb - 5'd1 : opp - 5'd1;

  assign s_axis_tready = (st_q == StIdle) && (!s_axis_tuser || !ovalid_q);
  assign acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = odata_q;

  always_comb begin
    st_d = st_q;
    cr_d = cr_q; cc_d = cc_q; nr_d = nr_q; nc_d = nc_q;
    dist_d = dist_q; bin_d = bin_q; k_d = k_q; ok_d = ok_q;
    fin = 1'b0;
    case (st_q)
      StIdle: begin
        if (acc && s_axis_tuser == OpCast) begin
          cr_d = s_axis_tdata[7:0];
          cc_d = s_axis_tdata[15:8];
          dist_d = '0; ok_d = 1'b0;
          if ({1'b0, s_axis_tdata[7:0]} < rows && {1'b0, s_axis_tdata[15:8]} < cols) begin
            st_d = StOrigin;
          end else begin
            st_d = StDone;
          end
        end
      end
      StOrigin: begin
        bin_d = rd_q[5:2];
        st_d = (5'(rd_q[5:2]) < nb) ? StStep : StDone;
      end
      StStep: begin
        if (!step_in) begin
          st_d = StDone;
        end else begin
          nr_d = RowW'(sr); nc_d = ColW'(sc);
          k_d = '0;
          st_d = StLand;
        end
      end
      StLand: begin
        if (rd_q[1]) begin
          st_d = StScan;
        end else begin
          cr_d = nr_q; cc_d = nc_q;
          dist_d = dist_q + 1'b1;
          if (rd_q[0]) begin
            ok_d = (5'(rd_q[5:2]) == opp) || (5'(rd_q[5:2]) == b1) ||
                   (5'(rd_q[5:2]) == b2);
            st_d = StDone;
          end else if (dist_q + 1'b1 > lim) begin
            st_d = StDone;
          end else begin
            st_d = StStep;
          end
        end
      end
      StScan: begin
        // rd_q holds neighbor k-1 when k > 0
        if (k_q != 4'd0 && n_in_prev && rd_q[0]) begin
          cr_d = pr_q; cc_d = pc_q;
          dist_d = dist_q + 1'b1;
          // snapped pixel is a boundary pixel
          ok_d = (5'(rd_q[5:2]) == opp) || (5'(rd_q[5:2]) == b1) ||
                 (5'(rd_q[5:2]) == b2);
          st_d = StDone;
        end else if (k_q == 4'd9) begin
          cr_d = nr_q; cc_d = nc_q;
          st_d = StDone;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      StDone: begin
        fin = 1'b1;
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_comb begin
    ren = 1'b0;
    raddr = {cr_q, cc_q};
    case (st_q)
      StIdle: begin
        ren = 1'b1;
        raddr = {s_axis_tdata[7:0], s_axis_tdata[15:8]};
      end
      StStep: begin
        ren = 1'b1;
        raddr = {RowW'(sr), ColW'(sc)};
      end
      StLand: begin
        ren = 1'b1;
        raddr = {nr_q, nc_q};
      end
      StScan: begin
        ren = n_in;
        raddr = {RowW'(mr), ColW'(mc)};
      end
      default: ren = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (acc && s_axis_tuser == OpWrite) begin
      mem_q[{s_axis_tdata[7:0], s_axis_tdata[15:8]}] <= s_axis_tdata[21:16];
    end
    if (ren) begin
      rd_q <= mem_q[raddr];
    end
    pr_q <= RowW'(mr);
    pc_q <= ColW'(mc);
    if (acc) begin
      org_r_q <= s_axis_tdata[7:0];
      org_c_q <= s_axis_tdata[15:8];
    end
    if (fin) begin
      odata_q <= {(ok_q ? dist_q : 7'd0), cc_q, cr_q, org_c_q, org_r_q, ok_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      rows_q <= 9'd256; cols_q <= 9'd256; mode_q <= 2'd0;
      cr_q <= '0; cc_q <= '0; nr_q <= '0; nc_q <= '0;
      dist_q <= '0; bin_q <= '0; k_q <= '0; ok_q <= 1'b0;
      ovalid_q <= 1'b0; n_in_prev <= 1'b0;
    end else begin
      st_q <= st_d;
      cr_q <= cr_d; cc_q <= cc_d; nr_q <= nr_d; nc_q <= nc_d;
      dist_q <= dist_d; bin_q <= bin_d; k_q <= k_d; ok_q <= ok_d;
      n_in_prev <= (st_q == StScan) && n_in;
      if (cfg_valid) begin
        case (cfg_index)
          CfgRows: rows_q <= cfg_data;
          CfgCols: cols_q <= cfg_data;
          CfgMode: mode_q <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (fin) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  a_no_cast_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StDone) |-> !ovalid_q) else $error("result overwritten");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StScan) |-> (k_q <= 4'd9)) else $error("scan index out of range");
  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> (dist_q <= 7'd86)) else $error("step count overrun");

endmodule

// ===== dv/stroke_width_ray_cast_checker.sv =====
module stroke_width_ray_cast_checker import swrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // pixel_row, pixel_col, is_boundary, gray_white, direction_bin, pad
  input  logic [23:0] s_axis_tdata,
  // operation
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // ray_ok, origin_row, origin_col, end_row, end_col, step_count
  input  logic [39:0] m_axis_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output int          fail_count_o,
  output int          pending_o
);

  // packed from the top bit down, so ok lands in bit 0
  typedef struct packed {
    logic [6:0] steps;
    logic [7:0] end_col;
    logic [7:0] end_row;
    logic [7:0] org_col;
    logic [7:0] org_row;
    logic       ok;
  } ray_t;

  localparam int D8R[8]   = '{0, -1, -1, -1, 0, 1, 1, 1};
  localparam int D8C[8]   = '{1, 1, 0, -1, -1, -1, 0, 1};
  localparam int D12R[12] = '{0, -1, -2, -1, -2, -1, 0, 1, 2, 1, 2, 1};
  localparam int D12C[12] = '{1, 2, 1, 0, -1, -2, -1, -2, -1, 0, 1, 2};
  localparam int D16R[16] = '{0, -1, -1, -2, -1, -2, -1, -1, 0, 1, 1, 2, 1, 2, 1, 1};
  localparam int D16C[16] = '{1, 2, 1, 1, 0, -1, -1, -2, -1, -2, -1, -1, 0, 1, 1, 2};

  logic [5:0] pix_mem [0:65535];
  ray_t       ray_q[$];
  int         rows_cfg;
  int         cols_cfg;
  int         mode_cfg;
  int         fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = ray_q.size();

  function automatic int clamp_size(input int v);
    return (v == 0) ? 1 : ((v > 256) ? 256 : v);
  endfunction

  function automatic ray_t trace_ray(input int r0, input int c0);
    int rows, cols, lim, nb, cr, cc, nsteps, bin, opp, b1, b2, dr, dc, nr, nc, m, n, g;
    logic ok, found, busy;
    logic [5:0] v;
    ray_t res;
    rows = clamp_size(rows_cfg);
    cols = clamp_size(cols_cfg);
    lim  = (rows < cols ? rows : cols) / 3;
    nb   = (mode_cfg == 0) ? 8 : ((mode_cfg == 1) ? 12 : 16);
    cr   = r0;
    cc   = c0;
    nsteps = 0;
    ok   = 1'b0;
    if (r0 < rows && c0 < cols) begin
      bin = int'(pix_mem[r0 * 256 + c0][5:2]);
      if (bin < nb) begin
        opp = (bin + nb / 2) % nb;
        b1  = (opp + 1) % nb;
        b2  = (opp + nb - 1) % nb;
        if (nb == 8) begin
          dr = D8R[bin];
          dc = D8C[bin];
        end else if (nb == 12) begin
          dr = D12R[bin];
          dc = D12C[bin];
        end else begin
          dr = D16R[bin];
          dc = D16C[bin];
        end
        busy = 1'b1;
        while (busy) begin
          nr = cr + dr;
          nc = cc + dc;
          if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) begin
            busy = 1'b0;
          end else begin
            v = pix_mem[nr * 256 + nc];
            found = 1'b1;
            if (v[1]) begin
              // white pixel: snap to first boundary pixel around it
              found = 1'b0;
              for (m = nr - 1; m <= nr + 1; m++) begin
                for (n = nc - 1; n <= nc + 1; n++) begin
                  if (!found && m >= 0 && m < rows && n >= 0 && n < cols) begin
                    if (pix_mem[m * 256 + n][0]) begin
                      found = 1'b1;
                      cr = m;
                      cc = n;
                    end
                  end
                end
              end
              if (!found) begin
                cr = nr;
                cc = nc;
                busy = 1'b0;
              end
            end else begin
              cr = nr;
              cc = nc;
            end
            if (found) begin
              nsteps++;
              v = pix_mem[cr * 256 + cc];
              if (v[0]) begin
                g = int'(v[5:2]);
                ok = (g == opp || g == b1 || g == b2);
                busy = 1'b0;
              end else if (nsteps > lim) begin
                busy = 1'b0;
              end
            end
          end
        end
      end
    end
    res.ok      = ok;
    res.org_row = 8'(r0);
    res.org_col = 8'(c0);
    res.end_row = 8'(cr);
    res.end_col = 8'(cc);
    res.steps   = ok ? 7'(nsteps) : 7'd0;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ray_t want, got;
    if (!rst_ni) begin
      ray_q.delete();
      rows_cfg   <= 256;
      cols_cfg   <= 256;
      mode_cfg   <= 0;
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgRows: rows_cfg <= int'(cfg_data);
          CfgCols: cols_cfg <= int'(cfg_data);
          CfgMode: mode_cfg <= int'(cfg_data[1:0]);
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OpWrite) begin
          pix_mem[{s_axis_tdata[7:0], s_axis_tdata[15:8]}] <= s_axis_tdata[21:16];
        end else begin
          ray_q.insert(ray_q.size(),
                       trace_ray(int'(s_axis_tdata[7:0]), int'(s_axis_tdata[15:8])));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[39:0];
        if (ray_q.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = ray_q.pop_front();
          if (got.ok != want.ok) report_mismatch("ray_ok", got.ok, want.ok);
          if (got.org_row != want.org_row) report_mismatch("origin_row", got.org_row, want.org_row);
          if (got.org_col != want.org_col) report_mismatch("origin_col", got.org_col, want.org_col);
          if (got.end_row != want.end_row) report_mismatch("end_row", got.end_row, want.end_row);
          if (got.end_col != want.end_col) report_mismatch("end_col", got.end_col, want.end_col);
          if (got.steps != want.steps) report_mismatch("step_count", got.steps, want.steps);
        end
      end
    end
  end

endmodule

// ===== dv/stroke_width_ray_cast_test.sv =====
module stroke_width_ray_cast_test import swrc_pkg::*;;

  localparam int QuietLimit = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // pixel_row, pixel_col, is_boundary, gray_white, direction_bin, pad
  logic [23:0] s_axis_tdata;
  // operation
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // ray_ok, origin_row, origin_col, end_row, end_col, step_count
  logic [39:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;
  int          fail_count;
  int          pending;

  bit          filled [0:65535];
  bit          calm;
  bit          hold_long;
  int          quiet_cycles;
  int          bin_count;
  int          base_bin;

  stroke_width_ray_cast uut (.*);

  stroke_width_ray_cast_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid, .cfg_ready,
    .cfg_index, .cfg_data, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("** stroke_width_ray_cast: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver side
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_long = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic int clamp_size(input int v);
    return (v == 0) ? 1 : ((v > 256) ? 256 : v);
  endfunction

  task automatic send_beat(input logic op, input int row, input int col,
                           input logic bnd, input logic wht, input int bin);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, 4'(bin), wht, bnd, 8'(col), 8'(row)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op == OpWrite) filled[row * 256 + col] = 1'b1;
  endtask

  task automatic write_pixel(input int row, input int col);
    int bin;
    logic bnd, wht;
    bnd = ($urandom_range(0, 99) < 35);
    wht = ($urandom_range(0, 99) < 20);
    if ($urandom_range(0, 99) < 8) bin = $urandom_range(0, 15);
    else if ($urandom_range(0, 1) == 0) bin = base_bin;
    else bin = (base_bin + bin_count / 2 + bin_count + $urandom_range(0, 2) - 1) % bin_count;
    send_beat(OpWrite, row, col, bnd, wht, bin);
  endtask

  task automatic drain_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 9'(value);
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // set up image size and bin mode, then fill every pixel a ray could read
  task automatic set_image(input int rows, input int cols, input int mode);
    int er, ec;
    drain_idle();
    write_reg(CfgRows, rows);
    write_reg(CfgCols, cols);
    write_reg(CfgMode, mode);
    bin_count = (mode == 0) ? 8 : ((mode == 1) ? 12 : 16);
    base_bin  = $urandom_range(0, bin_count - 1);
    er = clamp_size(rows);
    ec = clamp_size(cols);
    for (int r = 0; r < er; r++) begin
      for (int c = 0; c < ec; c++) begin
        if (!filled[r * 256 + c]) write_pixel(r, c);
      end
    end
  endtask

  task automatic run_mix(input int rows, input int cols, input int count);
    int er, ec;
    er = clamp_size(rows);
    ec = clamp_size(cols);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 4) == 0) write_pixel($urandom_range(0, 255), $urandom_range(0, 255));
        else write_pixel($urandom_range(0, er - 1), $urandom_range(0, ec - 1));
      end else if ($urandom_range(0, 9) == 0) begin
        send_beat(OpCast, $urandom_range(0, 255), $urandom_range(0, 255), 1'b0, 1'b0, 0);
      end else begin
        send_beat(OpCast, $urandom_range(0, er - 1), $urandom_range(0, ec - 1),
                  $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 15));
      end
    end
  endtask

  initial begin
    int rows, cols, mode;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OpWrite;
    cfg_valid     = 1'b0;
    cfg_index     = CfgRows;
    cfg_data      = '0;
    calm          = 1'b0;
    hold_long     = 1'b0;
    quiet_cycles  = 0;
    bin_count     = 8;
    base_bin      = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one-pixel image, origins outside, extreme write fields
    set_image(1, 1, 0);
    send_beat(OpCast, 0, 0, 1'b0, 1'b0, 0);
    send_beat(OpCast, 5, 0, 1'b0, 1'b0, 0);
    send_beat(OpWrite, 255, 255, 1'b1, 1'b1, 15);
    send_beat(OpWrite, 0, 0, 1'b1, 1'b0, 12);
    send_beat(OpCast, 255, 255, 1'b1, 1'b1, 15);
    send_beat(OpCast, 0, 0, 1'b0, 1'b0, 0);
    // zero rows, oversized cols, mode three
    set_image(0, 511, 3);
    send_beat(OpCast, 0, 0, 1'b0, 1'b0, 0);
    send_beat(OpCast, 0, 255, 1'b0, 1'b0, 0);
    send_beat(OpCast, 1, 3, 1'b0, 1'b0, 0);
    send_beat(OpWrite, 0, 10, 1'b0, 1'b0, 14);
    send_beat(OpCast, 0, 10, 1'b0, 1'b0, 0);
    run_mix(0, 511, 10);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin rows = 8; cols = 8; mode = 0; end
        1: begin rows = 4; cols = 12; mode = 1; end
        2: begin rows = 10; cols = 10; mode = 2; end
        3: begin rows = 7; cols = 7; mode = 3; end
        4: begin rows = 2; cols = 40; mode = 1; end
        5: begin rows = 10; cols = 12; mode = 0; end
        6: begin rows = $urandom_range(4, 10); cols = $urandom_range(4, 12);
                 mode = $urandom_range(0, 3); end
        default: begin rows = 9; cols = 12; mode = 2; end
      endcase
      if (p == 7) calm = 1'b1;
      set_image(rows, cols, mode);
      if (p == 2) hold_long = 1'b1;
      run_mix(rows, cols, 18);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** stroke_width_ray_cast: PASSED **");
    end else begin
      $display("** stroke_width_ray_cast: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/swrc_pkg.sv
hw/rtl/stroke_width_ray_cast.sv
dv/stroke_width_ray_cast_checker.sv
dv/stroke_width_ray_cast_test.sv
